// ===== rtl/template_match_classifier_core_defines.svh =====
// Assertion macros shared by the template match classifier RTL.
`ifndef TEMPLATE_MATCH_CLASSIFIER_CORE_DEFINES_SVH
`define TEMPLATE_MATCH_CLASSIFIER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define TMC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmc assertion failed");
// Next-cycle implication check.
`define TMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmc assertion failed");
`else
`define TMC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tmc_pkg.sv =====
// Shared constants, types and helpers of the template match classifier.
`default_nettype none
package tmc_pkg;

   // Store geometry.
   localparam int TEMPLATES = 256;
   localparam int PIXELS    = 600;

   // Derived widths.
   localparam int TIDX_W  = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
   localparam int PIX_W   = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int TADDR_W = ((TEMPLATES * PIXELS) > 1) ? $clog2(TEMPLATES * PIXELS) : 1;
   localparam int SCORE_W = $clog2(PIXELS + 1);

   // Fixed field widths.
   localparam int OP_W      = 2;
   localparam int TINDEX_W  = 8;
   localparam int PINDEX_W  = 10;
   localparam int VALUE_W   = 8;
   localparam int TOL_W     = 8;
   localparam int TIU_W     = 9;
   localparam int OUT_IDX_W = 8;
   localparam int OUT_SCR_W = 10;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 9;

   // Reset values of the configuration registers.
   localparam logic [TOL_W-1:0] TOL_RESET = 8'd21;
   localparam logic [TIU_W-1:0] TIU_RESET = 9'd256;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_TMPL_PIXEL = 2'd0;
   localparam logic [OP_W-1:0] OP_TMPL_LABEL = 2'd1;
   localparam logic [OP_W-1:0] OP_OBJECT     = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE        = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEMPLATES_IN_USE = 1'd1;

   // Control from the front end to the scorer.
   typedef struct packed {
      logic              go;
      logic [TOL_W-1:0]  tolerance;
      logic [TIDX_W-1:0] last_tmpl;
   } tmc_ctrl_type;

   // Result beat from the scorer.
   typedef struct packed {
      logic                 strobe;
      logic [OUT_IDX_W-1:0] best_index;
      logic [VALUE_W-1:0]   best_label;
      logic [OUT_SCR_W-1:0] best_score;
   } tmc_result_type;

   // Clamp a match count to the width of the result port.
   function automatic logic [OUT_SCR_W-1:0] sat_score(input logic [SCORE_W-1:0] s);
      logic [OUT_SCR_W-1:0] r;
      if (32'(s) > ((1 << OUT_SCR_W) - 1)) begin
         r = '1;
      end else begin
         r = OUT_SCR_W'(s);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tmc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module tmc_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; read data is registered.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/tmc_scorer.sv =====
// Scoring sequencer: walks the template store pixel by pixel and keeps the best.
`default_nettype none
module tmc_scorer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire tmc_pkg::tmc_ctrl_type          ctrl,
   output logic [tmc_pkg::TADDR_W-1:0]         tmpl_rd_addr,
   input  wire logic [tmc_pkg::VALUE_W-1:0]    tmpl_rd_data,
   output logic [tmc_pkg::PIX_W-1:0]           obj_rd_addr,
   input  wire logic [tmc_pkg::VALUE_W-1:0]    obj_rd_data,
   output logic [tmc_pkg::TIDX_W-1:0]          label_rd_addr,
   input  wire logic [tmc_pkg::VALUE_W-1:0]    label_rd_data,
   output logic                                busy,
   output tmc_pkg::tmc_result_type             result
);
   import tmc_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_OUT} state_type;

   state_type            state_ff, state_in;
   logic [TIDX_W-1:0]    tmpl_ff, tmpl_in;
   logic [PIX_W-1:0]     pix_ff, pix_in;
   logic [TADDR_W-1:0]   lin_ff, lin_in;
   logic [TIDX_W-1:0]    last_tmpl_ff;
   logic [TOL_W-1:0]     tol_ff;

   // Stage one: read data arrives.
   logic                 v1_ff, first1_ff, end1_ff;
   logic [TIDX_W-1:0]    t1_ff;
   // Stage two: match bit known.
   logic                 v2_ff, first2_ff, end2_ff, match2_ff;
   logic [TIDX_W-1:0]    t2_ff;

   logic [SCORE_W-1:0]   cnt_ff, cnt_in;
   logic [TIDX_W-1:0]    best_idx_ff;
   logic [SCORE_W-1:0]   best_score_ff;

   logic                 issue;
   logic                 pix_end;
   logic                 tmpl_end;
   logic [VALUE_W-1:0]   abs_diff;
   logic                 match1;
   logic                 better;

   // Walk control.
   always_comb begin
      issue    = (state_ff == S_RUN);
      pix_end  = (pix_ff == PIX_W'(PIXELS - 1));
      tmpl_end = (tmpl_ff == last_tmpl_ff);
      state_in = state_ff;
      tmpl_in  = tmpl_ff;
      pix_in   = pix_ff;
      lin_in   = lin_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctrl.go) begin
               state_in = S_RUN;
               tmpl_in  = '0;
               pix_in   = '0;
               lin_in   = '0;
            end
         end
         S_RUN: begin
            lin_in = lin_ff + 1'b1;
            if (pix_end) begin
               pix_in  = '0;
               tmpl_in = tmpl_ff + 1'b1;
               if (tmpl_end) begin
                  state_in = S_DRAIN;
               end
            end else begin
               pix_in = pix_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Pixel compare on the fresh read data.
   always_comb begin
      if (obj_rd_data > tmpl_rd_data) begin
         abs_diff = obj_rd_data - tmpl_rd_data;
      end else begin
         abs_diff = tmpl_rd_data - obj_rd_data;
      end
      match1 = (abs_diff <= tol_ff);
   end

   // Running count and best-so-far decision; the first template always wins.
   always_comb begin
      cnt_in = (first2_ff ? '0 : cnt_ff) + SCORE_W'(match2_ff);
      better = (t2_ff == '0) || (cnt_in > best_score_ff);
   end

   // State, pipeline and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
      end
      tmpl_ff   <= tmpl_in;
      pix_ff    <= pix_in;
      lin_ff    <= lin_in;
      first1_ff <= (pix_ff == '0);
      end1_ff   <= pix_end;
      t1_ff     <= tmpl_ff;
      first2_ff <= first1_ff;
      end2_ff   <= end1_ff;
      t2_ff     <= t1_ff;
      match2_ff <= match1;
      if (state_ff == S_IDLE && ctrl.go) begin
         last_tmpl_ff <= ctrl.last_tmpl;
         tol_ff       <= ctrl.tolerance;
      end
      if (v2_ff) begin
         cnt_ff <= cnt_in;
         if (end2_ff && better) begin
            best_idx_ff   <= t2_ff;
            best_score_ff <= cnt_in;
         end
      end
   end

   // Memory addresses and the result beat.
   assign tmpl_rd_addr      = lin_ff;
   assign obj_rd_addr       = pix_ff;
   assign label_rd_addr     = best_idx_ff;
   assign busy              = (state_ff != S_IDLE);
   assign result.strobe     = (state_ff == S_OUT);
   assign result.best_index = OUT_IDX_W'(best_idx_ff);
   assign result.best_label = label_rd_data;
   assign result.best_score = sat_score(best_score_ff);
endmodule
`default_nettype wire

// ===== rtl/template_match_classifier_core.sv =====
// Top level of the template match classifier: command decode, registers and stores.
`default_nettype none
`include "template_match_classifier_core_defines.svh"
// Template pixels, labels and object pixels are loaded one beat per cycle while
// busy is low, and busy stays low during loads. An object pixel beat with req_last
// set starts a classification: busy rises and stays high while the template store,
// which has one read port, is walked one pixel per cycle in template order through
// the templates in use. The result then appears for a single cycle with
// rsp_strobe high; the receiver cannot stall it, so it must take the beat in that
// cycle. The stores have no reset and need no clearing pass; entries never written
// read as unknown.
module template_match_classifier_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [tmc_pkg::OP_W-1:0]         req_op,
   input  wire logic [tmc_pkg::TINDEX_W-1:0]     req_template_index,
   input  wire logic [tmc_pkg::PINDEX_W-1:0]     req_pixel_index,
   input  wire logic [tmc_pkg::VALUE_W-1:0]      req_value,
   input  wire logic                             req_last,
   output logic                                  rsp_strobe,
   output logic [tmc_pkg::OUT_IDX_W-1:0]         rsp_best_index,
   output logic [tmc_pkg::VALUE_W-1:0]           rsp_best_label,
   output logic [tmc_pkg::OUT_SCR_W-1:0]         rsp_best_score,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tmc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tmc_pkg::CSR_DAT_W-1:0]    csr_data
);
   import tmc_pkg::*;

   logic [TOL_W-1:0]    tol_ff;
   logic [TIU_W-1:0]    tiu_ff;
   logic                accept;
   logic                pix_ok;
   logic                tix_ok;
   logic                tmpl_we;
   logic                label_we;
   logic                obj_we;
   logic [TADDR_W-1:0]  tmpl_wr_addr;
   logic [TIDX_W-1:0]   last_tmpl;
   tmc_ctrl_type        ctrl;
   tmc_result_type      result;
   logic [TADDR_W-1:0]  tmpl_rd_addr;
   logic [VALUE_W-1:0]  tmpl_rd_data;
   logic [PIX_W-1:0]    obj_rd_addr;
   logic [VALUE_W-1:0]  obj_rd_data;
   logic [TIDX_W-1:0]   label_rd_addr;
   logic [VALUE_W-1:0]  label_rd_data;

   // Configuration registers; the user must write them only while idle, the block does not enforce it.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
         tiu_ff <= TIU_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TOLERANCE:        tol_ff <= TOL_W'(csr_data);
            REG_TEMPLATES_IN_USE: tiu_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Command decode and store write addresses.
   always_comb begin
      accept       = start && !busy;
      pix_ok       = (32'(req_pixel_index) < PIXELS);
      tix_ok       = (32'(req_template_index) < TEMPLATES);
      tmpl_we      = accept && (req_op == OP_TMPL_PIXEL) && tix_ok && pix_ok;
      label_we     = accept && (req_op == OP_TMPL_LABEL) && tix_ok;
      obj_we       = accept && (req_op == OP_OBJECT) && pix_ok;
      tmpl_wr_addr = TADDR_W'(TADDR_W'(req_template_index) * TADDR_W'(PIXELS))
                     + TADDR_W'(req_pixel_index);
   end

   // Highest template index to score, with zero treated as one.
   always_comb begin
      if (tiu_ff == '0) begin
         last_tmpl = '0;
      end else if (32'(tiu_ff) > TEMPLATES) begin
         last_tmpl = TIDX_W'(TEMPLATES - 1);
      end else begin
         last_tmpl = TIDX_W'(tiu_ff - 1'b1);
      end
      ctrl.go        = accept && (req_op == OP_OBJECT) && req_last;
      ctrl.tolerance = tol_ff;
      ctrl.last_tmpl = last_tmpl;
   end

   // Template pixel store.
   tmc_ram #(.DEPTH(TEMPLATES * PIXELS), .WIDTH(VALUE_W)) u_tmpl_ram (
      .clock   (clock),
      .wr_en   (tmpl_we),
      .wr_addr (tmpl_wr_addr),
      .wr_data (req_value),
      .rd_addr (tmpl_rd_addr),
      .rd_data (tmpl_rd_data)
   );

   // Template label store.
   tmc_ram #(.DEPTH(TEMPLATES), .WIDTH(VALUE_W)) u_label_ram (
      .clock   (clock),
      .wr_en   (label_we),
      .wr_addr (TIDX_W'(req_template_index)),
      .wr_data (req_value),
      .rd_addr (label_rd_addr),
      .rd_data (label_rd_data)
   );

   // Object pixel buffer.
   tmc_ram #(.DEPTH(PIXELS), .WIDTH(VALUE_W)) u_obj_ram (
      .clock   (clock),
      .wr_en   (obj_we),
      .wr_addr (PIX_W'(req_pixel_index)),
      .wr_data (req_value),
      .rd_addr (obj_rd_addr),
      .rd_data (obj_rd_data)
   );

   // Scoring sequencer.
   tmc_scorer u_scorer (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .tmpl_rd_addr  (tmpl_rd_addr),
      .tmpl_rd_data  (tmpl_rd_data),
      .obj_rd_addr   (obj_rd_addr),
      .obj_rd_data   (obj_rd_data),
      .label_rd_addr (label_rd_addr),
      .label_rd_data (label_rd_data),
      .busy          (busy),
      .result        (result)
   );

   // Result beat.
   assign rsp_strobe     = result.strobe;
   assign rsp_best_index = result.best_index;
   assign rsp_best_label = result.best_label;
   assign rsp_best_score = result.best_score;

   // A classification start makes the block busy in the next cycle.
   `TMC_ASSERT_NEXT(a_go_busy, clock, reset, ctrl.go, busy)
   // A result beat is only shown while busy and ends the busy period.
   `TMC_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `TMC_ASSERT_NEXT(a_strobe_done, clock, reset, rsp_strobe, !busy)
   // No store is written while a classification runs.
   `TMC_ASSERT_IMP(a_no_write_busy, clock, reset, busy, !tmpl_we && !label_we && !obj_we)
endmodule
`default_nettype wire
